### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sor_pkg.sv
// Types, constants and codes of the segment offset reassembler.
package sor_pkg;

    localparam int unsigned BUF_BYTES_DEF = 4096;
    localparam int unsigned HDR_BYTES     = 3;
    localparam int unsigned LF_BIT        = 6;
    localparam logic [12:0] MAX_MSG_RESET = 13'd4096;

    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_ABORTED   = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT = 3'd4;
    localparam logic [2:0] ST_READ_DATA = 3'd5;

    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_ACCEPT = 4'b0010,
        MODE_DROP   = 4'b0100,
        MODE_ABORT  = 4'b1000
    } seg_mode_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [7:0]  seg_flags;
        logic [12:0] seg_len;
        logic [11:0] read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] msg_length;
        logic [7:0]  msg_flags;
        logic [7:0]  read_data;
        logic        rewound;
    } out_t;

    // Store write request; the address is always below the 13-bit window.
    typedef struct packed {
        logic        en;
        logic [12:0] addr;
        logic [7:0]  data;
    } wr_req_t;

    // Result of one transaction, read data still to be merged.
    typedef struct packed {
        logic valid;
        logic is_read;
        out_t item;
    } res_t;

endpackage

### rtl/sor_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sor_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/sor_ctrl.sv
// Segment header parsing, offset tracking and result decision.
module sor_ctrl (
    input  logic             clk,
    input  logic             rstn,
    input  logic             accept,
    input  sor_pkg::in_t     in_item,
    input  logic [12:0]      window,
    output sor_pkg::wr_req_t wr,
    output sor_pkg::res_t    res
);
    import sor_pkg::*;

    logic [12:0] pos_reg, pos_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [12:0] exp_reg, exp_next;
    seg_mode_t   mode_reg, mode_next;
    logic        rew_reg, rew_next;

    logic [23:0] hdr_cur;
    logic [12:0] exp_cur;
    logic [12:0] exp_fin;
    logic        rew_cur;
    seg_mode_t   mode_cur;
    logic [13:0] pay_len;
    logic [13:0] wr_addr;
    logic        last_byte;

    assign hdr_cur   = {hdr_reg[15:0], in_item.data_byte};
    assign pay_len   = {1'b0, in_item.seg_len} - 14'(HDR_BYTES);
    assign wr_addr   = {1'b0, exp_reg} + {1'b0, pos_reg} - 14'(HDR_BYTES);
    assign last_byte = ({1'b0, pos_reg} + 14'd1) >= {1'b0, in_item.seg_len};

    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        exp_next  = exp_reg;
        mode_next = mode_reg;
        rew_next  = rew_reg;
        exp_cur   = exp_reg;
        exp_fin   = exp_reg;
        rew_cur   = rew_reg;
        mode_cur  = mode_reg;
        wr        = '0;
        res       = '0;

        if (accept) begin
            if (in_item.cmd == CMD_READ) begin
                res.valid           = 1'b1;
                res.is_read         = 1'b1;
                res.item.status     = ST_READ_DATA;
                res.item.msg_length = exp_reg;
            end else begin
                unique case (mode_reg)
                    MODE_HEADER: begin
                        if (pos_reg == 13'(HDR_BYTES - 1)) begin
                            if (hdr_cur < {11'd0, exp_reg}) begin
                                exp_cur = hdr_cur[12:0];
                                rew_cur = 1'b1;
                            end
                            if (hdr_cur > {11'd0, exp_cur}) begin
                                mode_cur = MODE_DROP;
                            end else if (in_item.seg_len < 13'(HDR_BYTES) ||
                                         ({1'b0, exp_cur} + pay_len) > {1'b0, window}) begin
                                exp_cur  = '0;
                                mode_cur = MODE_ABORT;
                            end else begin
                                mode_cur = MODE_ACCEPT;
                            end
                        end
                    end
                    MODE_ACCEPT: begin
                        if (wr_addr < {1'b0, window}) begin
                            wr.en   = 1'b1;
                            wr.addr = wr_addr[12:0];
                            wr.data = in_item.data_byte;
                        end else begin
                            exp_cur  = '0;
                            mode_cur = MODE_ABORT;
                        end
                    end
                    default: ;
                endcase

                if (!last_byte) begin
                    pos_next  = pos_reg + 13'd1;
                    hdr_next  = hdr_cur;
                    exp_next  = exp_cur;
                    mode_next = mode_cur;
                    rew_next  = rew_cur;
                end else begin
                    res.valid = 1'b1;
                    exp_fin   = exp_cur;
                    unique case (mode_cur)
                        MODE_HEADER: res.item.status = ST_TOO_SHORT;
                        MODE_DROP:   res.item.status = ST_DROPPED;
                        MODE_ABORT: begin
                            res.item.status  = ST_ABORTED;
                            res.item.rewound = rew_cur;
                        end
                        MODE_ACCEPT: begin
                            exp_fin = 13'({1'b0, exp_cur} + {1'b0, pos_reg} + 14'd1
                                          - 14'(HDR_BYTES));
                            res.item.rewound = rew_cur;
                            if (in_item.seg_flags[LF_BIT]) begin
                                res.item.status    = ST_COMPLETE;
                                res.item.msg_flags = in_item.seg_flags;
                                res.item.msg_flags[LF_BIT] = 1'b0;
                            end else begin
                                res.item.status = ST_ACCEPTED;
                            end
                        end
                        default: res.item.status = ST_TOO_SHORT;
                    endcase
                    res.item.msg_length = exp_fin;
                    exp_next  = (res.item.status == ST_COMPLETE) ? 13'd0 : exp_fin;
                    pos_next  = '0;
                    hdr_next  = '0;
                    mode_next = MODE_HEADER;
                    rew_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            exp_reg  <= '0;
            mode_reg <= MODE_HEADER;
            rew_reg  <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            exp_reg  <= exp_next;
            mode_reg <= mode_next;
            rew_reg  <= rew_next;
        end
    end
endmodule

### rtl/segment_offset_reassembler.sv
// Top level of the segment offset reassembler.
//
// Input channel s_*: one transaction per segment byte (cmd segment) or per
// store read (cmd read). Segment bytes carry the 3-byte big-endian offset
// header first, then payload; flags and total length ride on every byte.
// Result channel m_*: one transaction on the last byte of each segment and
// one for every read; other segment bytes give none.
// Throughput: one input transaction per cycle while m_ready is high. The
// block takes a new transaction while a result waits in the output register.
// A result passes through the pipeline stage register and then the output
// register to m_*; the reassembly RAM's registered read data joins it at the stage.
// cfg_wr_en/cfg_wr_data set the largest message size; write it only while
// the block is idle.
// Reset: offset tracking returns to the header phase with expected offset 0
// and the size limit to 4096. The store is not cleared: read only written
// bytes. A stalled receiver holds m_data steady; s_ready drops once both
// the pipeline stage and the output register are full.
module segment_offset_reassembler #(
    parameter int unsigned BUF_BYTES = sor_pkg::BUF_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sor_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sor_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic [12:0]   cfg_wr_data
);
    import sor_pkg::*;

    localparam int unsigned ADDR_W   = $clog2(BUF_BYTES);
    localparam logic [31:0] BUF_SIZE = 32'(BUF_BYTES);

    logic [12:0] window_reg, window_next;
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_read_reg;
    logic        s1_oob_reg;
    out_t        s1_item_reg;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg;

    logic        accept;
    logic        advance;
    wr_req_t     wr;
    res_t        res;
    logic [7:0]  ram_rdata;
    logic        ram_re;
    out_t        s1_out;

    function automatic logic [12:0] clip_window(input logic [12:0] limit);
        return ({19'd0, limit} > BUF_SIZE) ? BUF_SIZE[12:0] : limit;
    endfunction

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign ram_re  = accept && (s_data.cmd == CMD_READ);

    sor_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .window  (window_reg),
        .wr      (wr),
        .res     (res)
    );

    sor_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .clk   (aclk),
        .we    (wr.en),
        .waddr (ADDR_W'(wr.addr)),
        .wdata (wr.data),
        .re    (ram_re),
        .raddr (ADDR_W'(s_data.read_index)),
        .rdata (ram_rdata)
    );

    always_comb begin
        window_next = cfg_wr_en ? clip_window(cfg_wr_data) : window_reg;

        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = res.valid;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // read data joins the item here, in the cycle after the RAM read
        s1_out = s1_item_reg;
        if (s1_read_reg && !s1_oob_reg) begin
            s1_out.read_data = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= clip_window(MAX_MSG_RESET);
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            window_reg   <= window_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= res.item;
            s1_read_reg <= res.is_read;
            s1_oob_reg  <= {20'd0, s_data.read_index} >= BUF_SIZE;
        end
        if (advance) begin
            m_data_reg <= s1_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

### rtl/sor_checker.sv
// Port-level checks of the reassembler result channel, bound to the top level.
`include "assert_macros.svh"

module sor_port_props (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input sor_pkg::out_t m_data
);
    import sor_pkg::*;

    logic out_stall;
    logic out_not_read;
    logic flags_ok;
    logic rew_status_ok;

    assign out_stall     = m_valid && !m_ready;
    assign out_not_read  = m_valid && m_data.status != ST_READ_DATA;
    assign flags_ok      = m_data.msg_flags == 8'd0 ||
                           (m_data.status == ST_COMPLETE && !m_data.msg_flags[LF_BIT]);
    assign rew_status_ok = m_data.status == ST_ACCEPTED || m_data.status == ST_COMPLETE ||
                           m_data.status == ST_ABORTED;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    `ASSERT_IMPL(a_read_data_only_on_read, aclk, aresetn, out_not_read, m_data.read_data == 8'd0)

    `ASSERT_IMPL(a_flags_only_on_complete, aclk, aresetn, m_valid, flags_ok)

    `ASSERT_IMPL(a_rewound_status, aclk, aresetn, m_valid && m_data.rewound, rew_status_ok)
endmodule

bind segment_offset_reassembler sor_port_props u_sor_port_props (.*);

### test/sor_checker.sv
// Checker for the segment offset reassembler: predicts each result and compares it.
module sor_checker
    import sor_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_t                      s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_t                     m_data,
    input  logic                     cfg_wr_en,
    input  logic [12:0]              cfg_wr_data,
    output int                       errors,
    output int                       pending,
    output int                       checked,
    output bit [BUF_BYTES_DEF-1:0]   stored
);

    logic [12:0] max_msg;
    logic [12:0] next_offset;
    logic [12:0] seg_pos;
    logic [23:0] hdr_offset;
    seg_mode_t   seg_mode;
    logic        rewind_flag;
    logic [7:0]  store_mem [0:BUF_BYTES_DEF-1];
    out_t        awaited_reports [$];

    // Advances the reassembly state by one transaction; give is set when it reports.
    function automatic void reassemble_byte(input in_t x, output bit give, output out_t rep);
        int unsigned win;
        int unsigned addr;
        int unsigned seg_bytes;
        logic [7:0]  flags;
        rep   = '0;
        give  = 1'b1;
        win   = (max_msg > BUF_BYTES_DEF) ? BUF_BYTES_DEF : max_msg;
        seg_bytes = x.seg_len;
        if (x.cmd == CMD_READ) begin
            rep.status     = ST_READ_DATA;
            rep.msg_length = next_offset;
            rep.read_data  = (x.read_index < BUF_BYTES_DEF) ? store_mem[x.read_index] : 8'h00;
            return;
        end
        if (seg_mode == MODE_HEADER) begin
            hdr_offset = {hdr_offset[15:0], x.data_byte};
            if (seg_pos == HDR_BYTES - 1) begin
                if (hdr_offset < next_offset) begin
                    next_offset = hdr_offset[12:0];
                    rewind_flag = 1'b1;
                end
                if (hdr_offset > next_offset) begin
                    seg_mode = MODE_DROP;
                end else if (seg_bytes < HDR_BYTES ||
                             next_offset + seg_bytes - HDR_BYTES > win) begin
                    next_offset = '0;
                    seg_mode    = MODE_ABORT;
                end else begin
                    seg_mode = MODE_ACCEPT;
                end
            end
        end else if (seg_mode == MODE_ACCEPT) begin
            addr = next_offset + seg_pos - HDR_BYTES;
            if (addr < win) begin
                store_mem[addr] = x.data_byte;
                stored[addr]    = 1'b1;
            end else begin
                next_offset = '0;
                seg_mode    = MODE_ABORT;
            end
        end
        if (seg_pos + 1 < seg_bytes) begin
            seg_pos = seg_pos + 1'b1;
            give    = 1'b0;
            return;
        end
        // last byte of the segment
        case (seg_mode)
            MODE_HEADER: begin
                rep.status  = ST_TOO_SHORT;
                rewind_flag = 1'b0;
            end
            MODE_DROP: begin
                rep.status  = ST_DROPPED;
                rewind_flag = 1'b0;
            end
            MODE_ABORT: begin
                rep.status = ST_ABORTED;
            end
            default: begin
                next_offset = 13'(next_offset + seg_pos + 1 - HDR_BYTES);
                if (x.seg_flags[LF_BIT]) begin
                    flags         = x.seg_flags;
                    flags[LF_BIT] = 1'b0;
                    rep.status    = ST_COMPLETE;
                    rep.msg_flags = flags;
                end else begin
                    rep.status = ST_ACCEPTED;
                end
            end
        endcase
        rep.msg_length = next_offset;
        rep.rewound    = rewind_flag;
        if (rep.status == ST_COMPLETE) begin
            next_offset = '0;
        end
        seg_pos     = '0;
        hdr_offset  = '0;
        seg_mode    = MODE_HEADER;
        rewind_flag = 1'b0;
    endfunction

    always @(posedge aclk) begin
        bit   give;
        out_t rep;
        out_t want;
        if (!aresetn) begin
            max_msg     = MAX_MSG_RESET;
            next_offset = '0;
            seg_pos     = '0;
            hdr_offset  = '0;
            seg_mode    = MODE_HEADER;
            rewind_flag = 1'b0;
            stored      = '0;
            errors      = 0;
            checked     = 0;
            awaited_reports.delete();
        end else begin
            // compare first: a result never leaves in the cycle its transaction enters
            if (m_valid && m_ready) begin
                checked++;
                if (awaited_reports.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected result: status %0d len %0d flags %02h data %02h rew %0d",
                                 m_data.status, m_data.msg_length, m_data.msg_flags,
                                 m_data.read_data, m_data.rewound);
                    end
                    errors++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_data.status != want.status || m_data.msg_length != want.msg_length ||
                        m_data.msg_flags != want.msg_flags || m_data.read_data != want.read_data ||
                        m_data.rewound != want.rewound) begin
                        if (errors < 10) begin
                            $display("mismatch: exp status %0d len %0d flags %02h data %02h rew %0d",
                                     want.status, want.msg_length, want.msg_flags,
                                     want.read_data, want.rewound);
                            $display("          got status %0d len %0d flags %02h data %02h rew %0d",
                                     m_data.status, m_data.msg_length, m_data.msg_flags,
                                     m_data.read_data, m_data.rewound);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                max_msg = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                reassemble_byte(s_data, give, rep);
                if (give) begin
                    awaited_reports.insert(awaited_reports.size(), rep);
                end
            end
        end
        pending = awaited_reports.size();
    end

endmodule

### test/tb_segment_offset_reassembler.sv
// Testbench top for the segment offset reassembler: stimulus, pacing and verdict.
module tb_segment_offset_reassembler;
    import sor_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_t         s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_t        m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [12:0] cfg_wr_data = '0;

    int                     errors;
    int                     pending;
    int                     checked;
    bit [BUF_BYTES_DEF-1:0] stored_map;

    bit hold_req = 1'b0;
    bit no_idle  = 1'b0;
    int steer_off = 0;
    int win_now   = MAX_MSG_RESET;
    int n_items   = 0;
    int n_segs    = 0;
    int n_reads   = 0;
    int n_windows = 0;

    always #1 aclk = ~aclk;

    segment_offset_reassembler DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    sor_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .stored      (stored_map)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input in_t x);
        int g;
        bit taken;
        g = no_idle ? 0 : gap_cycles();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        n_items++;
    endtask

    // Reads only bytes that have been written; want < 0 picks one at random.
    task automatic send_read(input int want);
        in_t x;
        int  idx;
        int  k;
        idx = (want >= 0) ? want : $urandom_range(0, BUF_BYTES_DEF - 1);
        for (k = 0; k < BUF_BYTES_DEF && !stored_map[idx]; k++) begin
            idx = (idx + 1) % BUF_BYTES_DEF;
        end
        if (!stored_map[idx]) return;
        x.cmd        = CMD_READ;
        x.data_byte  = 8'($urandom);
        x.seg_flags  = 8'($urandom);
        x.seg_len    = 13'($urandom);
        x.read_index = 12'(idx);
        send_item(x);
        n_reads++;
    endtask

    // Header bytes carry len_hdr (unless one is the last byte), the rest len_tail.
    task automatic send_seg(input logic [23:0] off, input logic [7:0] flags, input int n,
                            input int len_hdr, input int len_tail);
        in_t x;
        int  i;
        int  l2;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 6) send_read(-1);
            x.cmd        = CMD_SEGMENT;
            x.data_byte  = (i < HDR_BYTES) ? off[23 - 8 * i -: 8] : 8'($urandom);
            x.seg_flags  = flags;
            x.seg_len    = 13'((i < HDR_BYTES && i < n - 1) ? len_hdr : len_tail);
            x.read_index = 12'($urandom);
            send_item(x);
        end
        // keep track of the expected offset so most segments land in order
        if (n >= HDR_BYTES) begin
            l2 = (n == HDR_BYTES) ? len_tail : len_hdr;
            if (off <= steer_off) begin
                steer_off = off;
                if (l2 < HDR_BYTES || steer_off + l2 - HDR_BYTES > win_now ||
                    steer_off + n - HDR_BYTES > win_now || flags[LF_BIT]) begin
                    steer_off = 0;
                end else begin
                    steer_off = steer_off + n - HDR_BYTES;
                end
            end
        end
        n_segs++;
    endtask

    task automatic set_window(input int v);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        // a segment byte gives no result, so let the pipeline settle
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 13'(v);
        win_now = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_windows++;
    endtask

    task automatic random_traffic(input int quota);
        int          first;
        int          r;
        int          room;
        int          a;
        int          b;
        logic [23:0] o;
        logic [7:0]  f;
        first = n_items;
        while (n_items - first < quota) begin
            r = $urandom_range(0, 99);
            f = 8'($urandom);
            f[LF_BIT] = ($urandom_range(0, 3) == 0);
            o = 24'(steer_off);
            if (r >= 55 && r < 65 && steer_off > 0) begin
                o = 24'($urandom_range(0, steer_off - 1));
            end else if (r >= 65 && r < 72) begin
                o = $urandom_range(0, 1) ? 24'(steer_off + $urandom_range(1, 3))
                                         : 24'($urandom);
            end
            room = win_now - int'(o);
            a = (room > 0) ? $urandom_range(0, (room < 12) ? room : 12) : 0;
            if (r < 72) begin
                send_seg(o, f, HDR_BYTES + a, HDR_BYTES + a, HDR_BYTES + a);
            end else if (r < 80) begin
                // too big for the window where that is cheap to reach
                if (room <= 40) a = ((room > 0) ? room : 0) + $urandom_range(1, 4);
                send_seg(o, f, HDR_BYTES + a, HDR_BYTES + a, HDR_BYTES + a);
            end else if (r < 86) begin
                // length grows inside the segment, may run past the window
                if (a == 0) a = 1;
                b = $urandom_range(1, 6);
                send_seg(o, f, HDR_BYTES + a + b, HDR_BYTES + a, HDR_BYTES + a + b);
            end else if (r < 92) begin
                a = $urandom_range(0, 2);
                send_seg(o, f, (a == 0) ? 1 : a, a, a);
            end else if (r < 96) begin
                // length shrinks below the header on the third byte
                send_seg($urandom_range(0, 1) ? o : 24'($urandom), f, HDR_BYTES,
                         $urandom_range(5, 8191), $urandom_range(0, 2));
            end else begin
                send_read(-1);
            end
        end
    endtask

    // Receiver pacing, with one long hold-off on request.
    initial begin : rx_pace
        int g;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            g = no_idle ? 0 : gap_cycles();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: short and zero lengths, in order, rewind, drops, shrink, grow
        send_seg(24'h000000, 8'h00, 1, 0, 0);
        send_seg(24'h000000, 8'h00, 1, 1, 1);
        send_seg(24'h000000, 8'h00, 2, 2, 2);
        send_seg(24'h000000, 8'h00, 3, 3, 3);
        send_seg(24'h000000, 8'hFF, 7, 7, 7);
        send_seg(24'h000000, 8'h00, 8, 8, 8);
        send_read(0);
        send_seg(24'h000002, 8'h3C, 6, 6, 6);
        send_seg(24'h000009, 8'h00, 4, 4, 4);
        send_seg(24'hFFFFFF, 8'hBF, 4, 4, 4);
        send_seg(24'h000005, 8'h00, 3, 8191, 0);
        send_seg(24'h000000, 8'h40, 5, 5, 5);
        send_seg(24'h000000, 8'h00, 9, 5, 9);
        set_window(16);
        send_seg(24'h000006, 8'h40, 14, 14, 14);
        send_seg(24'h000000, 8'h00, 23, 19, 23);
        send_seg(24'h000000, 8'h40, 19, 19, 19);
        set_window(0);
        send_seg(24'h000000, 8'h40, 3, 3, 3);
        send_seg(24'h000000, 8'h00, 4, 4, 4);
        set_window(4096);
        // one complete message from offset zero, then both of its ends read back
        send_seg(24'h000000, 8'hC5, 67, 67, 67);
        send_read(0);
        send_read(63);

        set_window(16);
        random_traffic(145);
        set_window(0);
        random_traffic(145);
        set_window(4096);
        hold_req = 1'b1;
        random_traffic(145);
        set_window(1);
        random_traffic(145);
        set_window(300);
        no_idle = 1'b1;
        random_traffic(145);
        no_idle = 1'b0;
        set_window(4095);
        random_traffic(145);
        set_window(64);
        random_traffic(145);
        set_window($urandom_range(2, 4096));
        random_traffic(145);

        s_valid <= 1'b0;
        k = 0;
        do begin
            @(negedge aclk);
            k++;
        end while (pending != 0 && k < 50000);
        repeat (10) @(posedge aclk);

        $display("Run: %0d transactions in, %0d segments and %0d store reads, %0d window writes",
                 n_items, n_segs, n_reads, n_windows);
        $display("Run: %0d results compared, %0d errors", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
